/* hw/rtl/windowed_valid_sample_average_unit_assert.svh */
// Assertion macros for the windowed valid-sample average unit.
`ifndef WINDOWED_VALID_SAMPLE_AVERAGE_UNIT_ASSERT_SVH
`define WINDOWED_VALID_SAMPLE_AVERAGE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define WSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define WSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/wsa_pkg.sv */
package wsa_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 7;
    localparam int OUT_BITS    = 7;
    localparam int SLOT_BITS   = $clog2(WINDOW_MAX);
    localparam int LEN_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
    localparam int DIV_BITS    = SUM_BITS;
    localparam int CNT_BITS    = $clog2(DIV_BITS + 1);
    localparam int LEN_RESET   = 10;
    localparam int PCT_SCALE   = 100;

    typedef logic [SLOT_BITS-1:0] t_slot_idx;
    typedef logic [LEN_BITS-1:0]  t_len;

    typedef struct packed {
        logic                   valid;
        logic [SAMPLE_BITS-1:0] value;
    } t_slot;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_START,
        S_DIV
    } t_state;

endpackage

/* hw/rtl/wsa_sample_if.sv */
interface wsa_sample_if;
    import wsa_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] temperature;
    logic                          sample_valid;

    modport source (output valid, output temperature, output sample_valid, input ready);
    modport sink   (input valid, input temperature, input sample_valid, output ready);
endinterface

/* hw/rtl/wsa_result_if.sv */
interface wsa_result_if;
    import wsa_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average_temperature;
    logic                          average_defined;
    logic [OUT_BITS-1:0]           percent_valid;
    logic [OUT_BITS-1:0]           samples_held;

    modport source (output valid, output average_temperature, output average_defined,
                    output percent_valid, output samples_held, input ready);
    modport sink   (input valid, input average_temperature, input average_defined,
                    input percent_valid, input samples_held, output ready);
endinterface

/* hw/rtl/wsa_cfg_if.sv */
interface wsa_cfg_if;
    import wsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

/* hw/rtl/wsa_ring.sv */
module wsa_ring (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  wsa_pkg::t_slot_idx i_wr_addr,
    input  wsa_pkg::t_slot   i_wr_data,
    input  logic             i_rd_en,
    input  wsa_pkg::t_slot_idx i_rd_addr,
    output wsa_pkg::t_slot   o_rd_data
);
    import wsa_pkg::*;

    t_slot r_mem [WINDOW_MAX];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* hw/rtl/wsa_div.sv */
// Restoring divider, one quotient bit per cycle.
module wsa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wsa_pkg::DIV_BITS-1:0]  i_dividend,
    input  wsa_pkg::t_len                 i_divisor,
    output logic                          o_busy,
    output logic [wsa_pkg::DIV_BITS-1:0]  o_quotient
);
    import wsa_pkg::*;

    logic                r_busy;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DIV_BITS-1:0] r_quo;
    t_len                r_rem;
    t_len                r_divisor;

    logic [LEN_BITS:0]   w_trial;
    logic [LEN_BITS:0]   w_diff;
    logic                w_ge;

    assign w_trial = {r_rem, r_quo[DIV_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign w_ge    = w_trial >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(DIV_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[LEN_BITS-1:0] : w_trial[LEN_BITS-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

/* hw/rtl/windowed_valid_sample_average_unit.sv */
// Channel    Dir  Type           Payload
// i_sample   in   wsa_sample_if  temperature, sample_valid
// o_result   out  wsa_result_if  average_temperature, average_defined,
//                                percent_valid, samples_held
// i_cfg      in   wsa_cfg_if     window_length
//
// i_sample.ready is high only in S_IDLE, so each item runs through S_UPDATE, S_START and S_DIV
// before the next i_sample transfer; o_result.valid rises once S_DIV loads the result register.
// The 22-step bit-serial dividers for mean and percentage run while the state is S_DIV.
// The result register frees the input side: a new item is taken while a result waits.
// A finished result stalls only if the previous one is still not taken.
// Synchronous active-low reset: window_length 10, store empty, both readies low. No clearing pass.
module windowed_valid_sample_average_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wsa_sample_if.sink   i_sample,
    wsa_result_if.source o_result,
    wsa_cfg_if.sink      i_cfg
);
    import wsa_pkg::*;
    `include "windowed_valid_sample_average_unit_assert.svh"

    t_state r_state, n_state;

    logic [CFG_BITS-1:0]           r_window_length;
    t_slot_idx                     r_write_slot, n_write_slot;
    t_len                          r_fill, n_fill;
    logic signed [SUM_BITS-1:0]    r_sum, n_sum;
    t_len                          r_count, n_count;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_valid;
    t_slot_idx                     r_slot;
    logic                          r_neg;

    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_avg;
    logic                          r_out_def;
    logic [OUT_BITS-1:0]           r_out_pct;
    logic [OUT_BITS-1:0]           r_out_held;

    t_len                          w_len;
    t_slot_idx                     w_slot;
    t_len                          w_slot_inc;
    logic                          w_in_xfer;
    logic                          w_cfg_xfer;
    logic                          w_full;
    logic                          w_drop;
    logic                          w_load;
    logic                          w_start;
    logic                          w_can_load;
    logic                          w_wr_en;
    t_slot                         w_rd_data;
    t_slot                         w_wr_data;
    logic signed [SUM_BITS-1:0]    w_old_ext;
    logic signed [SUM_BITS-1:0]    w_new_ext;
    logic [DIV_BITS-1:0]           w_mag;
    logic [DIV_BITS-1:0]           w_pct_num;
    logic [DIV_BITS-1:0]           w_avg_q;
    logic [DIV_BITS-1:0]           w_pct_q;
    logic                          w_avg_busy;
    logic                          w_pct_busy;
    logic [SAMPLE_BITS-1:0]        w_q16;
    logic signed [SAMPLE_BITS-1:0] w_avg;

    // Effective window length: zero acts as one, saturated at WINDOW_MAX.
    always_comb begin
        if (r_window_length == '0) begin
            w_len = t_len'(1);
        end else if (int'(r_window_length) > WINDOW_MAX) begin
            w_len = t_len'(WINDOW_MAX);
        end else begin
            w_len = t_len'(r_window_length);
        end
    end

    assign w_slot     = (t_len'(r_write_slot) >= w_len) ? '0 : r_write_slot;
    assign w_slot_inc = t_len'(r_slot) + t_len'(1);

    assign i_sample.ready = i_rst_n && (r_state == S_IDLE);
    assign i_cfg.ready    = i_rst_n;
    assign w_in_xfer      = i_sample.valid & i_sample.ready;
    assign w_cfg_xfer     = i_cfg.valid & i_cfg.ready;

    wsa_ring u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_in_xfer),
        .i_rd_addr (w_slot),
        .o_rd_data (w_rd_data)
    );

    assign w_wr_data.valid = r_valid;
    assign w_wr_data.value = r_sample;

    assign w_full    = r_fill >= w_len;
    assign w_drop    = w_full & w_rd_data.valid;
    assign w_old_ext = w_drop  ? SUM_BITS'($signed(w_rd_data.value)) : '0;
    assign w_new_ext = r_valid ? SUM_BITS'(r_sample) : '0;

    assign w_mag     = r_sum[SUM_BITS-1] ? DIV_BITS'(-r_sum) : DIV_BITS'(r_sum);
    assign w_pct_num = DIV_BITS'(r_count) * DIV_BITS'(PCT_SCALE);

    wsa_div u_div_avg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_mag),
        .i_divisor  (r_count),
        .o_busy     (w_avg_busy),
        .o_quotient (w_avg_q)
    );

    wsa_div u_div_pct (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_pct_num),
        .i_divisor  (r_fill),
        .o_busy     (w_pct_busy),
        .o_quotient (w_pct_q)
    );

    assign w_q16 = w_avg_q[SAMPLE_BITS-1:0];
    always_comb begin
        if (r_count == '0) begin
            w_avg = '0;
        end else if (r_neg) begin
            w_avg = -$signed(w_q16);
        end else begin
            w_avg = $signed(w_q16);
        end
    end

    assign w_can_load = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_write_slot = r_write_slot;
        n_fill       = r_fill;
        n_sum        = r_sum;
        n_count      = r_count;
        w_wr_en      = 1'b0;
        w_start      = 1'b0;
        w_load       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                w_wr_en      = 1'b1;
                n_sum        = r_sum - w_old_ext + w_new_ext;
                n_count      = r_count - t_len'(w_drop) + t_len'(r_valid);
                n_fill       = w_full ? r_fill : r_fill + t_len'(1);
                n_write_slot = (w_slot_inc >= w_len) ? '0 : w_slot_inc[SLOT_BITS-1:0];
                n_state      = S_START;
            end
            S_START: begin
                w_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!w_avg_busy && !w_pct_busy && w_can_load) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_cfg_xfer) begin
            n_write_slot = '0;
            n_fill       = '0;
            n_sum        = '0;
            n_count      = '0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= CFG_BITS'(LEN_RESET);
            r_write_slot    <= '0;
            r_fill          <= '0;
            r_sum           <= '0;
            r_count         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (w_cfg_xfer) begin
                r_window_length <= i_cfg.window_length;
            end
            r_write_slot <= n_write_slot;
            r_fill       <= n_fill;
            r_sum        <= n_sum;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_sample <= i_sample.temperature;
            r_valid  <= i_sample.sample_valid;
            r_slot   <= w_slot;
        end
        if (w_start) begin
            r_neg <= r_sum[SUM_BITS-1];
        end
        if (w_load) begin
            r_out_avg  <= w_avg;
            r_out_def  <= (r_count != '0);
            r_out_pct  <= w_pct_q[OUT_BITS-1:0];
            r_out_held <= OUT_BITS'(r_fill);
        end
    end

    assign o_result.valid               = r_out_valid;
    assign o_result.average_temperature = r_out_avg;
    assign o_result.average_defined     = r_out_def;
    assign o_result.percent_valid       = r_out_pct;
    assign o_result.samples_held        = r_out_held;

    `WSA_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= w_len, "fill beyond window")
    `WSA_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= r_fill, "valid count above fill")
    `WSA_ASSERT_IMP(a_slot_bound, i_clk, i_rst_n, 1'b1, t_len'(r_write_slot) < w_len, "slot outside window")
    `WSA_ASSERT_NXT(a_accept_update, i_clk, i_rst_n, w_in_xfer, r_state == S_UPDATE, "no update after transfer")
    `WSA_ASSERT_NXT(a_load_valid, i_clk, i_rst_n, w_load, r_out_valid, "result not presented")
endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_PHASES  = 14;

    localparam logic signed [SAMPLE_BITS-1:0] TEMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] TEMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY4, STALL_LONG} t_stall_kind;
    typedef enum int {TEMP_FULL, TEMP_EXTREME, TEMP_SMALL} t_temp_kind;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] average_temperature;
        logic                          average_defined;
        logic [OUT_BITS-1:0]           percent_valid;
        logic [OUT_BITS-1:0]           samples_held;
    } t_window_stats;

    logic clk;
    logic rst_n;

    wsa_sample_if sample_ch ();
    wsa_result_if result_ch ();
    wsa_cfg_if    cfg_ch ();

    windowed_valid_sample_average_unit dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // shadow of the window store
    longint        ring_temp [WINDOW_MAX];
    bit            ring_ok   [WINDOW_MAX];
    int unsigned   next_slot;
    int unsigned   held;
    int unsigned   valid_n;
    longint        valid_total;
    logic [CFG_BITS-1:0] window_reg;

    t_window_stats pending_stats[$];

    int fail_count;
    int items_sent;
    int results_checked;
    int cfg_writes;
    int undefined_seen;
    int burst_left;
    int idle_cycles;

    t_stall_kind stall_mode;
    int          stall_mode_left;
    int          stall_tick;
    int          hold_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void clear_window();
        next_slot   = 0;
        held        = 0;
        valid_n     = 0;
        valid_total = 0;
    endfunction

    function automatic void predict_stats(logic signed [SAMPLE_BITS-1:0] temp, logic vld);
        int unsigned   span;
        int unsigned   slot;
        t_window_stats e;
        span = (window_reg == 0) ? 1 : ((window_reg > WINDOW_MAX) ? WINDOW_MAX : window_reg);
        slot = (next_slot >= span) ? 0 : next_slot;
        if (held >= span) begin
            if (ring_ok[slot]) begin
                valid_total -= ring_temp[slot];
                valid_n--;
            end
        end else begin
            held++;
        end
        ring_temp[slot] = longint'(temp);
        ring_ok[slot]   = vld;
        if (vld) begin
            valid_total += longint'(temp);
            valid_n++;
        end
        slot++;
        next_slot = (slot >= span) ? 0 : slot;

        e.average_temperature = (valid_n != 0) ?
            SAMPLE_BITS'(valid_total / longint'(valid_n)) : '0;
        e.average_defined = (valid_n != 0);
        e.percent_valid   = OUT_BITS'((valid_n * 100) / held);
        e.samples_held    = OUT_BITS'(held);
        if (!e.average_defined) undefined_seen++;
        pending_stats = {pending_stats, e};
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_temperature(t_temp_kind kind);
        int v;
        case (kind)
            TEMP_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return TEMP_MIN;
                    1: return TEMP_MAX;
                    2: return -1;
                    3: return 0;
                    default: return 1;
                endcase
            end
            TEMP_SMALL: begin
                v = int'($urandom_range(0, 400)) - 200;
                return SAMPLE_BITS'(v);
            end
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic void check_field(string name, int want, int seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] temp, input logic vld);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0) begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        sample_ch.valid        <= 1'b1;
        sample_ch.temperature  <= temp;
        sample_ch.sample_valid <= vld;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        predict_stats(temp, vld);
        items_sent++;
    endtask

    task automatic stop_samples();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_results_drained();
        while (pending_stats.size() != 0) @(posedge clk);
    endtask

    task automatic write_window_length(input logic [CFG_BITS-1:0] len);
        stop_samples();
        wait_results_drained();
        @(negedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.window_length <= len;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        window_reg = len;
        clear_window();
        cfg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // reset window of 10, no register write yet
    task automatic test_default_window();
        send_sample(0, 1'b0);
        send_sample(TEMP_MAX, 1'b0);
        send_sample(TEMP_MIN, 1'b1);
        send_sample(TEMP_MAX, 1'b1);
        send_sample(-3, 1'b1);
        send_sample(-4, 1'b1);
        send_sample(1, 1'b1);
        send_sample(-1, 1'b0);
        send_sample(TEMP_MAX, 1'b1);
        send_sample(TEMP_MAX, 1'b1);
        send_sample(0, 1'b1);
        send_sample(TEMP_MIN, 1'b1);
        send_sample(-1, 1'b1);
    endtask

    // zero acts as one, anything above the max saturates
    task automatic test_length_limits();
        write_window_length(0);
        send_sample(100, 1'b1);
        send_sample(5, 1'b0);
        send_sample(TEMP_MIN, 1'b1);
        send_sample(-1, 1'b1);
        write_window_length(7'h7f);
        send_sample(TEMP_MAX, 1'b1);
        send_sample(-7, 1'b1);
        send_sample(2, 1'b0);
    endtask

    task automatic test_rewrite_clears();
        write_window_length(2);
        send_sample(7, 1'b1);
        send_sample(-9, 1'b1);
        write_window_length(2);
        send_sample(4, 1'b1);
    endtask

    task automatic test_random_windows();
        int         lengths[10] = '{1, 2, 3, 10, 63, 64, 65, 127, 0, 32};
        int         densities[5] = '{0, 10, 50, 90, 100};
        int         count;
        int         density;
        t_temp_kind kind;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_window_length(p < 10 ? CFG_BITS'(lengths[p]) : CFG_BITS'($urandom_range(0, 127)));
            count   = $urandom_range(60, 130);
            density = densities[$urandom_range(0, 4)];
            for (int i = 0; i < count; i++) begin
                kind = t_temp_kind'($urandom_range(0, 2));
                send_sample(pick_temperature(kind), $urandom_range(0, 99) < density);
            end
        end
    endtask

    always @(negedge clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      = t_stall_kind'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(50, 400);
        end
        stall_mode_left--;
        case (stall_mode)
            STALL_NONE: begin
                result_ch.ready <= 1'b1;
            end
            STALL_COIN: begin
                result_ch.ready <= $urandom_range(0, 1);
            end
            STALL_EVERY4: begin
                stall_tick++;
                result_ch.ready <= (stall_tick % 4 == 0);
            end
            default: begin
                if (hold_left != 0) begin
                    hold_left--;
                    result_ch.ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    hold_left = $urandom_range(10, 40);
                    result_ch.ready <= 1'b0;
                end else begin
                    result_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge clk) begin
        t_window_stats want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_stats.size() == 0) begin
                $error("result transfer with no sample pending");
                fail_count++;
            end else begin
                want = pending_stats.pop_front();
                results_checked++;
                check_field("average_temperature", int'(want.average_temperature),
                            int'(result_ch.average_temperature));
                check_field("average_defined", int'(want.average_defined),
                            int'(result_ch.average_defined));
                check_field("percent_valid", int'(want.percent_valid),
                            int'(result_ch.percent_valid));
                check_field("samples_held", int'(want.samples_held),
                            int'(result_ch.samples_held));
            end
        end
    end

    always @(posedge clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("windowed_valid_sample_average_unit test failed");
            $finish;
        end
    end

    initial begin
        rst_n                  = 1'b0;
        sample_ch.valid        = 1'b0;
        sample_ch.temperature  = '0;
        sample_ch.sample_valid = 1'b0;
        result_ch.ready        = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.window_length   = '0;
        fail_count      = 0;
        items_sent      = 0;
        results_checked = 0;
        cfg_writes      = 0;
        undefined_seen  = 0;
        burst_left      = 0;
        idle_cycles     = 0;
        stall_mode      = STALL_NONE;
        stall_mode_left = 0;
        stall_tick      = 0;
        hold_left       = 0;
        window_reg      = CFG_BITS'(LEN_RESET);
        clear_window();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_window();
        test_length_limits();
        test_rewrite_clears();
        test_random_windows();

        stop_samples();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d samples, %0d results checked, %0d window length writes",
                 items_sent, results_checked, cfg_writes);
        $display("%0d results had no valid sample in the window", undefined_seen);
        if (fail_count == 0 && pending_stats.size() == 0)
            $display("windowed_valid_sample_average_unit test passed");
        else
            $display("windowed_valid_sample_average_unit test failed");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/wsa_pkg.sv
hw/rtl/wsa_sample_if.sv
hw/rtl/wsa_result_if.sv
hw/rtl/wsa_cfg_if.sv
hw/rtl/wsa_ring.sv
hw/rtl/wsa_div.sv
hw/rtl/windowed_valid_sample_average_unit.sv
tb/tb.sv
